// ===== sv/dual_rate_integral_learner_defines.svh =====
// Assertion macros shared by the dual-rate integral learner RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef DUAL_RATE_INTEGRAL_LEARNER_DEFINES_SVH
`define DUAL_RATE_INTEGRAL_LEARNER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define DRIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define DRIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DRIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DRIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/dril_pkg.sv =====
// Shared widths, register indexes and transaction types of the dual-rate
// integral learner. Has no dependencies; used by dril_step and the top level.
package dril_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int ACC_WIDTH     = 24;
    localparam int DELAY_WIDTH   = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int FRAC_BITS     = 12;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_FAST_PROP_GAIN = 3'd0,
        CFG_FAST_INT_GAIN  = 3'd1,
        CFG_SLOW_PROP_GAIN = 3'd2,
        CFG_SLOW_INT_GAIN  = 3'd3,
        CFG_LOWER_LIMIT    = 3'd4,
        CFG_START_DELAY    = 3'd5,
        CFG_TWO_SIDED      = 3'd6,
        CFG_LEARNER_OFFSET = 3'd7
    } t_cfg_idx;

    // Input transaction.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] error_in;
        logic signed [DATA_WIDTH-1:0] base_in;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] control_out;
        logic signed [ACC_WIDTH-1:0]  correction;
        logic signed [ACC_WIDTH-1:0]  integral_out;
    } t_out_item;

    // Configuration register set.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] fast_prop_gain;
        logic signed [DATA_WIDTH-1:0] fast_int_gain;
        logic signed [DATA_WIDTH-1:0] slow_prop_gain;
        logic signed [DATA_WIDTH-1:0] slow_int_gain;
        logic signed [DATA_WIDTH-1:0] lower_limit;
        logic [DELAY_WIDTH-1:0]       start_delay;
        logic                         two_sided;
        logic signed [DATA_WIDTH-1:0] learner_offset;
    } t_cfg;

    // Learner state carried from one transaction to the next.
    typedef struct packed {
        logic [DELAY_WIDTH-1:0]       tick_count;
        logic signed [DATA_WIDTH-1:0] base_level;
        logic signed [ACC_WIDTH-1:0]  integral_acc;
        logic signed [DATA_WIDTH-1:0] last_output;
    } t_state;

endpackage

// ===== sv/dril_step.sv =====
// One update step of the learner: next state and result from the current
// state, the configuration and one input transaction. Depends on dril_pkg.
module dril_step (
    input  dril_pkg::t_cfg      i_cfg,
    input  dril_pkg::t_state    i_state,
    input  dril_pkg::t_in_item  i_item,
    output dril_pkg::t_state    o_state,
    output dril_pkg::t_out_item o_result
);

    localparam int DW    = dril_pkg::DATA_WIDTH;
    localparam int AW    = dril_pkg::ACC_WIDTH;
    localparam int SUM_W = DW + AW + 2;

    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        SUM_W'(1) <<< (dril_pkg::FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] ACC_MAX = (SUM_W'(1) <<< (AW - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
    localparam logic signed [AW:0]      DATA_MAX = (AW + 1)'((AW + 1)'(1) <<< (DW - 1))
                                                   - (AW + 1)'(1);

    logic                         active;
    logic signed [DW-1:0]         e_eff;
    logic signed [DW-1:0]         bl;
    logic signed [AW-1:0]         ia;
    logic signed [AW:0]           ia_sum;
    logic signed [AW-1:0]         ia_new;
    logic signed [DW:0]           gain_p;
    logic signed [DW:0]           gain_i;
    logic signed [DW+AW:0]        prod_i;
    logic signed [2*DW:0]         prod_p;
    logic signed [SUM_W-1:0]      acc_sum;
    logic signed [SUM_W-1:0]      corr_full;
    logic signed [AW-1:0]         corr;
    logic signed [AW:0]           ctl_full;
    logic signed [DW-1:0]         ctl;
    logic signed [AW-1:0]         ia_final;
    logic [dril_pkg::DELAY_WIDTH-1:0] tick_next;

    // Error gating, base relatch and integral clearing rules.
    always_comb begin
        e_eff     = i_item.error_in;
        bl        = i_state.base_level;
        ia        = i_state.integral_acc;
        tick_next = i_state.tick_count;
        active    = i_state.tick_count > i_cfg.start_delay;

        if (i_item.error_in == '0) begin
            bl = i_item.base_in;
            ia = '0;
        end

        if (active) begin
            if (i_cfg.two_sided && (e_eff <= 0) && (i_state.last_output >= bl)) begin
                e_eff = '0;
                ia    = '0;
            end
            if (!i_cfg.two_sided && (e_eff < 0)) begin
                e_eff = '0;
                ia    = '0;
            end
            if (bl == '0) begin
                ia = '0;
            end
        end else begin
            if (i_state.tick_count != '1) begin
                tick_next = i_state.tick_count + 1'b1;
            end
            bl    = i_item.base_in;
            e_eff = '0;
            ia    = '0;
        end
    end

    // Saturating integral update.
    always_comb begin
        ia_sum = (AW + 1)'(ia) + (AW + 1)'(e_eff);
        if (ia_sum[AW] != ia_sum[AW-1]) begin
            ia_new = ia_sum[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
        end else begin
            ia_new = ia_sum[AW-1:0];
        end
    end

    // Combined fast and slow gains; the integral term uses the whole
    // integral, which equals the split high and low product form.
    always_comb begin
        gain_p    = (DW + 1)'(i_cfg.fast_prop_gain) + (DW + 1)'(i_cfg.slow_prop_gain);
        gain_i    = (DW + 1)'(i_cfg.fast_int_gain) + (DW + 1)'(i_cfg.slow_int_gain);
        prod_i    = gain_i * ia_new;
        prod_p    = gain_p * e_eff;
        acc_sum   = SUM_W'(prod_i) + SUM_W'(prod_p) + ROUND_HALF;
        corr_full = (acc_sum >>> dril_pkg::FRAC_BITS) + SUM_W'(i_cfg.learner_offset);
        if (corr_full > ACC_MAX) begin
            corr = ACC_MAX[AW-1:0];
        end else if (corr_full < ACC_MIN) begin
            corr = ACC_MIN[AW-1:0];
        end else begin
            corr = corr_full[AW-1:0];
        end
    end

    // Output floor with anti-windup, then saturation to the data range.
    always_comb begin
        ctl_full = (AW + 1)'(bl) - (AW + 1)'(corr);
        ia_final = ia_new;
        if (ctl_full < (AW + 1)'(i_cfg.lower_limit)) begin
            ctl      = i_cfg.lower_limit;
            ia_final = ia;
        end else if (ctl_full > DATA_MAX) begin
            ctl = DATA_MAX[DW-1:0];
        end else begin
            ctl = ctl_full[DW-1:0];
        end
    end

    assign o_state.tick_count    = tick_next;
    assign o_state.base_level    = bl;
    assign o_state.integral_acc  = ia_final;
    assign o_state.last_output   = ctl;
    assign o_result.control_out  = ctl;
    assign o_result.correction   = corr;
    assign o_result.integral_out = ia_final;

endmodule

// ===== sv/dual_rate_integral_learner.sv =====
// Top level of the dual-rate integral learner: configuration registers,
// input and result registers around dril_step. Depends on dril_pkg, dril_step
// and dual_rate_integral_learner_defines.svh.
//
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_data carries one error sample
//   and one candidate base level per transaction. Result channel o_out_valid /
//   i_out_stall / o_out_data carries control output, correction and integral.
//   A transaction moves at a rising edge with valid high and stall low.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes one
//   register per cycle; write it only while no transaction is in flight.
//   An accepted transaction is held in the input register, then in the result register.
//   Throughput: one transaction per cycle while the receiver does not stall.
//   The learner state feeds back around dril_step, which updates it in the
//   cycle a transaction moves from the input register to the result register.
//   When the receiver stalls, the result register holds, the input register
//   keeps one more transaction, and then o_in_stall rises.
//   Synchronous reset clears the state, empties both registers and loads the
//   register defaults (all zero, two_sided set).
`include "dual_rate_integral_learner_defines.svh"

module dual_rate_integral_learner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dril_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [dril_pkg::DATA_WIDTH-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  dril_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output dril_pkg::t_out_item                 o_out_data
);

    dril_pkg::t_cfg      r_cfg;
    dril_pkg::t_state    r_state;
    dril_pkg::t_state    n_state;
    dril_pkg::t_in_item  r_in;
    dril_pkg::t_out_item r_out;
    dril_pkg::t_out_item n_out;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                out_free;
    logic                advance;
    logic                in_take;

    // Handshake control of the two register stages.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg           <= '0;
            r_cfg.two_sided <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (dril_pkg::t_cfg_idx'(i_cfg_idx))
                dril_pkg::CFG_FAST_PROP_GAIN: r_cfg.fast_prop_gain <= i_cfg_data;
                dril_pkg::CFG_FAST_INT_GAIN:  r_cfg.fast_int_gain  <= i_cfg_data;
                dril_pkg::CFG_SLOW_PROP_GAIN: r_cfg.slow_prop_gain <= i_cfg_data;
                dril_pkg::CFG_SLOW_INT_GAIN:  r_cfg.slow_int_gain  <= i_cfg_data;
                dril_pkg::CFG_LOWER_LIMIT:    r_cfg.lower_limit    <= i_cfg_data;
                dril_pkg::CFG_START_DELAY:
                    r_cfg.start_delay <= i_cfg_data[dril_pkg::DELAY_WIDTH-1:0];
                dril_pkg::CFG_TWO_SIDED:      r_cfg.two_sided      <= i_cfg_data[0];
                dril_pkg::CFG_LEARNER_OFFSET: r_cfg.learner_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Update step between the input register and the result register.
    dril_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Valid flags and learner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks on the stage control and the learner state.
    `DRIL_ASSERT_IMP(a_stall_needs_full, i_clk, i_rst_n, o_in_stall, r_in_valid,
        "input stall raised with an empty input register")
    `DRIL_ASSERT_NXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid,
        "result register empty after a transaction advanced")
    `DRIL_ASSERT_NXT(a_output_above_floor, i_clk, i_rst_n, advance,
        $signed(r_out.control_out) >= $signed($past(r_cfg.lower_limit)),
        "control output below the lower limit")
    `DRIL_ASSERT_NXT(a_tick_monotonic, i_clk, i_rst_n, 1'b1,
        r_state.tick_count >= $past(r_state.tick_count),
        "start-delay counter went backward")
    `DRIL_ASSERT_NXT(a_stalled_result_holds, i_clk, i_rst_n,
        r_out_valid && i_out_stall, r_out_valid && $stable(r_out),
        "stalled result transaction changed or vanished")

endmodule
